// ===== design/rbm_pkg.sv =====
// ----------------------------------------------------------------------------
// rbm_pkg
// Shared sizes, codes and types of the 4-connected region boundary marker.
// ----------------------------------------------------------------------------
`default_nettype none

package rbm_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int HIST_DEPTH = 2 * MAX_WIDTH + 1;

   // fixed field widths
   localparam int PIX_W     = 8;
   localparam int DIM_W     = 9;
   localparam int CSR_IDX_W = 1;

   // derived widths
   localparam int ADDR_W = $clog2(HIST_DEPTH);
   localparam int CNT_W  = $clog2(HIST_DEPTH + 1);
   localparam int OFF_W  = $clog2(HIST_DEPTH + MAX_WIDTH);

   // largest size a DIM_W register can ask for
   localparam int DIM_MAX    = (1 << DIM_W) - 1;
   localparam int WIDTH_LIM  = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
   localparam int HEIGHT_LIM = (MAX_HEIGHT < DIM_MAX) ? MAX_HEIGHT : DIM_MAX;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'd1;

   localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 9'd160;
   localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 9'd120;

   // one neighbor lookup: examined at all, slot never written, take the new pixel
   typedef struct packed {
      logic chk;
      logic unwritten;
      logic bypass;
   } nbr_type;

   typedef struct packed {
      logic    center_ok;
      logic    left_chk;
      nbr_type up;
      nbr_type right;
      nbr_type down;
      logic    frame_end;
   } cls_ctl_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] dim,
                                                  input logic [DIM_W-1:0] lim);
      logic [DIM_W-1:0] res;
      res = dim;
      if (dim == '0) begin
         res = DIM_W'(1);
      end else if (dim > lim) begin
         res = lim;
      end
      return res;
   endfunction

   function automatic logic nbr_zero(input nbr_type n,
                                     input logic [PIX_W-1:0] rd,
                                     input logic [PIX_W-1:0] new_pix);
      logic [PIX_W-1:0] v;
      v = n.bypass ? new_pix : rd;
      return n.chk && (n.unwritten || (v == '0));
   endfunction

endpackage

`default_nettype wire

// ===== design/rbm_ram.sv =====
// ----------------------------------------------------------------------------
// rbm_ram
// Simple dual-read RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module rbm_ram #(
   parameter int DATA_W = 8,
   parameter int ADDR_W = 10
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr_a,
   input  wire logic [ADDR_W-1:0] rd_addr_b,
   output logic      [DATA_W-1:0] rd_data_a,
   output logic      [DATA_W-1:0] rd_data_b
);

   logic [DATA_W-1:0] mem_ff [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_a_ff;
   logic [DATA_W-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read returns the old contents on a same-edge write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

// ===== design/region_boundary_marker_4n_top.sv =====
// ----------------------------------------------------------------------------
// region_boundary_marker_4n_top
// 4-connected boundary marking of a raster stream of label pixels.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request per cycle when req_stall is low: a pixel (req_op = pixel) or a
//   drain request that flushes one pending pixel. Pixels come in raster order.
//   rsp_* returns the classified pixels in raster order: 0 background,
//   own label on a region boundary, 1 inside a region; rsp_frame_end flags
//   the last pixel of a frame. A pixel comes out once the pixel one row
//   below it has arrived, or when a drain request pushes it out.
//   csr_* writes frame_width / frame_height; write only while idle.
// Timing:
//   One request per cycle sustained while rsp_stall is low. A result that an
//   accepted request releases passes through the registered line-buffer RAM
//   read and then the output register before it appears on rsp_valid.
//   The history lives in two RAM copies of 2**ADDR_W bytes, two reads each.
// Reset:
//   Sizes return to 160 x 120, all counters clear; the history reads as
//   zero through a fill count, so no clearing pass is needed.
// Stall:
//   rsp_stall holds the output register; the read stage keeps one result
//   behind it, and req_stall rises only when both are full and rsp is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module region_boundary_marker_4n_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic                           req_op,
   input  wire logic [rbm_pkg::PIX_W-1:0]      req_pixel_in,
   // result channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic      [rbm_pkg::PIX_W-1:0]      rsp_marked_pixel,
   output logic                                rsp_frame_end,
   // register writes
   input  wire logic                           csr_wr_en,
   input  wire logic [rbm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rbm_pkg::DIM_W-1:0]      csr_wdata
);

   import rbm_pkg::*;

   // configuration
   logic [DIM_W-1:0] frame_width_ff;
   logic [DIM_W-1:0] frame_height_ff;

   // stream position state
   logic [CNT_W-1:0]  pending_ff, pending_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [ADDR_W-1:0] wp_ff, wp_in;
   logic [DIM_W-1:0]  out_col_ff, out_col_in;
   logic [DIM_W-1:0]  out_row_ff, out_row_in;

   // read stage
   logic              b_valid_ff, b_valid_in;
   cls_ctl_type       b_ctl_ff, b_ctl_in;
   logic [PIX_W-1:0]  b_pixel_ff;
   logic [PIX_W-1:0]  last_center_ff;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]  rsp_pixel_ff, rsp_pixel_in;
   logic              rsp_frame_end_ff;

   logic [DIM_W-1:0]  w, h;
   logic              is_pixel, accept, emit;
   logic [CNT_W-1:0]  pend_arr, fill_arr;
   logic [ADDR_W-1:0] wp_arr, top_addr;
   logic [OFF_W-1:0]  o, off_up, off_right, off_down, fill_x, w_x;
   logic [DIM_W:0]    col_p1, row_p1;
   logic [ADDR_W-1:0] addr_center, addr_up, addr_right, addr_down;
   logic [PIX_W-1:0]  rd_center, rd_up, rd_right, rd_down;
   logic [PIX_W-1:0]  center;
   logic              edge_hit, out_load, b_free;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign w = clamp_dim(frame_width_ff, DIM_W'(WIDTH_LIM));
   assign h = clamp_dim(frame_height_ff, DIM_W'(HEIGHT_LIM));

   // ------------------------------------------------------------ handshake
   assign out_load  = b_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign b_free    = !b_valid_ff || out_load;
   assign req_stall = !b_free;
   assign accept    = req_valid && b_free;
   assign is_pixel  = (req_op == OP_PIXEL);

   // ------------------------------------------------- request stage decode
   always_comb begin
      pend_arr = pending_ff;
      fill_arr = fill_ff;
      wp_arr   = wp_ff;
      if (is_pixel) begin
         wp_arr = wp_ff + ADDR_W'(1);
         if (pending_ff < CNT_W'(HIST_DEPTH)) pend_arr = pending_ff + CNT_W'(1);
         if (fill_ff < CNT_W'(HIST_DEPTH))    fill_arr = fill_ff + CNT_W'(1);
      end
   end

   assign w_x    = OFF_W'(w);
   assign fill_x = OFF_W'(fill_arr);
   assign emit   = is_pixel ? (OFF_W'(pend_arr) > w_x) : (pending_ff != '0);

   // oldest pending pixel sits at history offset o, newest at offset 0
   assign o         = OFF_W'(pend_arr) - OFF_W'(1);
   assign off_up    = o + w_x;
   assign off_right = o - OFF_W'(1);
   assign off_down  = o - w_x;

   assign top_addr    = wp_arr - ADDR_W'(1);
   assign addr_center = top_addr - ADDR_W'(o);
   assign addr_up     = top_addr - ADDR_W'(off_up);
   assign addr_right  = top_addr - ADDR_W'(off_right);
   assign addr_down   = top_addr - ADDR_W'(off_down);

   assign col_p1 = {1'b0, out_col_ff} + (DIM_W+1)'(1);
   assign row_p1 = {1'b0, out_row_ff} + (DIM_W+1)'(1);

   always_comb begin
      b_ctl_in.center_ok       = (o < fill_x);
      b_ctl_in.left_chk        = (out_col_ff != '0);
      b_ctl_in.up.chk          = (out_row_ff != '0) && (off_up < OFF_W'(HIST_DEPTH));
      b_ctl_in.up.unwritten    = (off_up >= fill_x);
      b_ctl_in.up.bypass       = 1'b0;
      b_ctl_in.right.chk       = (col_p1 < {1'b0, w}) && (o != '0);
      b_ctl_in.right.unwritten = (off_right >= fill_x);
      // the pixel written at this edge is not yet visible in the RAM
      b_ctl_in.right.bypass    = is_pixel && (off_right == '0);
      b_ctl_in.down.chk        = (row_p1 < {1'b0, h}) && (o >= w_x);
      b_ctl_in.down.unwritten  = (off_down >= fill_x);
      b_ctl_in.down.bypass     = is_pixel && (off_down == '0);
      b_ctl_in.frame_end       = (row_p1 >= {1'b0, h}) && (col_p1 >= {1'b0, w});
   end

   always_comb begin
      pending_in = pend_arr;
      fill_in    = fill_arr;
      wp_in      = wp_arr;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      b_valid_in = accept && emit;
      if (emit) begin
         pending_in = pend_arr - CNT_W'(1);
         if (col_p1 >= {1'b0, w}) begin
            out_col_in = '0;
            out_row_in = (row_p1 >= {1'b0, h}) ? '0 : row_p1[DIM_W-1:0];
         end else begin
            out_col_in = col_p1[DIM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         fill_ff    <= '0;
         wp_ff      <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            pending_ff <= pending_in;
            fill_ff    <= fill_in;
            wp_ff      <= wp_in;
            out_col_ff <= out_col_in;
            out_row_ff <= out_row_in;
         end
         if (b_free) begin
            b_valid_ff <= b_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_ctl_ff   <= b_ctl_in;
         b_pixel_ff <= req_pixel_in;
      end
   end

   // ----------------------------------------------------------- history RAM
   rbm_ram #(
      .DATA_W (PIX_W),
      .ADDR_W (ADDR_W)
   ) u_ram_cu (
      .clock     (clock),
      .wr_en     (accept && is_pixel),
      .wr_addr   (wp_ff),
      .wr_data   (req_pixel_in),
      .rd_en     (accept),
      .rd_addr_a (addr_center),
      .rd_addr_b (addr_up),
      .rd_data_a (rd_center),
      .rd_data_b (rd_up)
   );

   rbm_ram #(
      .DATA_W (PIX_W),
      .ADDR_W (ADDR_W)
   ) u_ram_rd (
      .clock     (clock),
      .wr_en     (accept && is_pixel),
      .wr_addr   (wp_ff),
      .wr_data   (req_pixel_in),
      .rd_en     (accept),
      .rd_addr_a (addr_right),
      .rd_addr_b (addr_down),
      .rd_data_a (rd_right),
      .rd_data_b (rd_down)
   );

   // --------------------------------------------------------- classify
   // left neighbor is always the previously emitted center pixel
   assign center   = b_ctl_ff.center_ok ? rd_center : '0;
   assign edge_hit = (b_ctl_ff.left_chk && (last_center_ff == '0))
                  || nbr_zero(b_ctl_ff.up,    rd_up,    b_pixel_ff)
                  || nbr_zero(b_ctl_ff.right, rd_right, b_pixel_ff)
                  || nbr_zero(b_ctl_ff.down,  rd_down,  b_pixel_ff);

   always_comb begin
      if (center == '0) begin
         rsp_pixel_in = '0;
      end else if (edge_hit) begin
         rsp_pixel_in = center;
      end else begin
         rsp_pixel_in = PIX_W'(1);
      end
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         last_center_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (out_load) begin
            last_center_ff <= center;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_pixel_ff     <= rsp_pixel_in;
         rsp_frame_end_ff <= b_ctl_ff.frame_end;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_marked_pixel = rsp_pixel_ff;
   assign rsp_frame_end    = rsp_frame_end_ff;

endmodule

`default_nettype wire
